### sv/fcsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcsp_pkg
// Types, command codes, register indexes and the angle-to-ticks table shared
// by the five-channel servo pulse generator.
// ----------------------------------------------------------------------------
package fcsp_pkg;

  // Number of angle fields carried by one input word
  localparam int ANGLE_INPUTS = 5;

  // Register reset values
  localparam logic [15:0] PERIOD_TICKS_RESET = 16'd62500;
  localparam logic [15:0] PULSE_LIMIT_RESET  = 16'd6755;
  localparam logic [15:0] PULSE_BASE_RESET   = 16'd1750;

  // Configuration register indexes
  localparam logic [1:0] REG_PERIOD_TICKS = 2'd0;
  localparam logic [1:0] REG_PULSE_LIMIT  = 2'd1;
  localparam logic [1:0] REG_PULSE_BASE   = 2'd2;

  // Width saturation value
  localparam logic [15:0] WIDTH_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_SET_ONE  = 3'd1,
    CMD_SET_ALL  = 3'd2,
    CMD_GET_ONE  = 3'd3,
    CMD_GET_ALL  = 3'd4,
    CMD_FREE_ONE = 3'd5,
    CMD_FREE_ALL = 3'd6,
    CMD_REINIT   = 3'd7
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t   command;
    logic [2:0]  servo_id;
    logic [7:0]  angle_0;
    logic [7:0]  angle_1;
    logic [7:0]  angle_2;
    logic [7:0]  angle_3;
    logic [7:0]  angle_4;
  } fcsp_cmd_t;

  typedef struct packed {
    logic [4:0]  pwm_lines;
    logic        read_valid;
    logic [7:0]  read_pos_a;
    logic [7:0]  read_pos_b;
    logic [7:0]  read_pos_c;
    logic [7:0]  read_pos_d;
    logic [7:0]  read_pos_e;
  } fcsp_res_t;

  typedef struct packed {
    logic [15:0] period_ticks;
    logic [15:0] pulse_limit;
    logic [15:0] pulse_base;
  } fcsp_cfg_t;

  typedef logic [12:0] angle_ticks_t;

  // floor(angle * 27.8) for every 8-bit angle, worked out at elaboration
  function automatic angle_ticks_t [255:0] build_angle_ticks();
    angle_ticks_t [255:0] tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = 13'((i * 278) / 10);
    end
    return tab;
  endfunction

  localparam angle_ticks_t [255:0] ANGLE_TICKS = build_angle_ticks();

endpackage
`default_nettype wire

### sv/fcsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcsp_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface fcsp_cmd_if
  import fcsp_pkg::*;
();
  logic      valid;
  logic      ready;
  fcsp_cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fcsp_res_if
  import fcsp_pkg::*;
();
  logic      valid;
  logic      ready;
  fcsp_res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/fcsp_width.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcsp_width
// Pulse width for one angle: base + floor(angle * 27.8), saturating at 65535.
// ----------------------------------------------------------------------------
module fcsp_width
  import fcsp_pkg::*;
(
  input  logic [7:0]  angle,
  input  logic [15:0] base,
  output logic [15:0] width
);

  logic [16:0] sum;

  // table lookup plus one 17-bit add
  assign sum   = {1'b0, base} + 17'(ANGLE_TICKS[angle]);
  assign width = sum[16] ? WIDTH_MAX : sum[15:0];

endmodule
`default_nettype wire

### sv/fcsp_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcsp_core
// Servo state (counter, angles, widths, enables, line levels) and the
// update for one command word; also forms the result word.
// ----------------------------------------------------------------------------
module fcsp_core
  import fcsp_pkg::*;
#(
  parameter int SERVO_COUNT = 5
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      go,
  input  fcsp_cmd_t item,
  input  fcsp_cfg_t cfg,
  output fcsp_res_t result
);

  logic [15:0]            period_count, period_count_next;
  logic [15:0]            pulse_width      [SERVO_COUNT];
  logic [15:0]            pulse_width_next [SERVO_COUNT];
  logic [7:0]             angle_store      [SERVO_COUNT];
  logic [7:0]             angle_store_next [SERVO_COUNT];
  logic [SERVO_COUNT-1:0] enable_bits, enable_bits_next;
  logic [SERVO_COUNT-1:0] line_levels, line_levels_next;

  logic [7:0]  angle_in  [ANGLE_INPUTS];
  logic [7:0]  unit_angle [SERVO_COUNT];
  logic [15:0] unit_width [SERVO_COUNT];
  logic [7:0]  read_all  [ANGLE_INPUTS];
  logic [7:0]  read_one;
  logic [7:0]  lines_ext;
  logic        id_ok;
  logic        restart;

  assign angle_in[0] = item.angle_0;
  assign angle_in[1] = item.angle_1;
  assign angle_in[2] = item.angle_2;
  assign angle_in[3] = item.angle_3;
  assign angle_in[4] = item.angle_4;

  assign id_ok   = item.servo_id < 3'(SERVO_COUNT);
  assign restart = period_count >= cfg.period_ticks;

  // one width unit per servo; unit 0 also serves set one (angle_0)
  for (genvar n = 0; n < SERVO_COUNT; n++) begin : g_unit
    if (n < ANGLE_INPUTS) begin : g_in
      assign unit_angle[n] = angle_in[n];
    end else begin : g_zero
      assign unit_angle[n] = '0;
    end
    fcsp_width u_width (
      .angle (unit_angle[n]),
      .base  (cfg.pulse_base),
      .width (unit_width[n])
    );
  end

  // next state for the current word
  always_comb begin
    period_count_next = period_count;
    enable_bits_next  = enable_bits;
    line_levels_next  = line_levels;
    for (int n = 0; n < SERVO_COUNT; n++) begin
      pulse_width_next[n] = pulse_width[n];
      angle_store_next[n] = angle_store[n];
    end
    unique case (item.command)
      CMD_TICK: begin
        if (restart) begin
          period_count_next = '0;
          line_levels_next  = enable_bits;
        end else begin
          if (period_count >= cfg.pulse_limit) begin
            line_levels_next = '0;
          end else begin
            for (int n = 0; n < SERVO_COUNT; n++) begin
              if (period_count >= pulse_width[n]) begin
                line_levels_next[n] = 1'b0;
              end
            end
          end
          period_count_next = period_count + 16'd1;
        end
      end
      CMD_SET_ONE: begin
        for (int n = 0; n < SERVO_COUNT; n++) begin
          if (id_ok && item.servo_id == 3'(n)) begin
            angle_store_next[n] = item.angle_0;
            pulse_width_next[n] = unit_width[0];
            enable_bits_next[n] = 1'b1;
          end
        end
      end
      CMD_SET_ALL: begin
        for (int n = 0; n < SERVO_COUNT; n++) begin
          angle_store_next[n] = unit_angle[n];
          pulse_width_next[n] = unit_width[n];
        end
        enable_bits_next = '1;
      end
      CMD_FREE_ONE: begin
        for (int n = 0; n < SERVO_COUNT; n++) begin
          if (id_ok && item.servo_id == 3'(n)) begin
            enable_bits_next[n] = 1'b0;
          end
        end
      end
      CMD_FREE_ALL: begin
        enable_bits_next = '0;
      end
      CMD_REINIT: begin
        for (int n = 0; n < SERVO_COUNT; n++) begin
          pulse_width_next[n] = cfg.pulse_base;
          angle_store_next[n] = '0;
        end
        enable_bits_next  = '0;
        line_levels_next  = '0;
        period_count_next = '0;
      end
      CMD_GET_ONE, CMD_GET_ALL: begin
      end
      default: begin
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      period_count <= '0;
      enable_bits  <= '0;
      line_levels  <= '0;
      for (int n = 0; n < SERVO_COUNT; n++) begin
        pulse_width[n] <= PULSE_BASE_RESET;
        angle_store[n] <= '0;
      end
    end else if (go) begin
      period_count <= period_count_next;
      enable_bits  <= enable_bits_next;
      line_levels  <= line_levels_next;
      for (int n = 0; n < SERVO_COUNT; n++) begin
        pulse_width[n] <= pulse_width_next[n];
        angle_store[n] <= angle_store_next[n];
      end
    end
  end

  // position reads
  for (genvar n = 0; n < ANGLE_INPUTS; n++) begin : g_read
    if (n < SERVO_COUNT) begin : g_have
      assign read_all[n] = angle_store[n];
    end else begin : g_none
      assign read_all[n] = '0;
    end
  end

  always_comb begin
    read_one = '0;
    for (int n = 0; n < SERVO_COUNT; n++) begin
      if (item.servo_id == 3'(n)) begin
        read_one = angle_store[n];
      end
    end
  end

  // result word
  assign lines_ext = 8'(line_levels_next);

  always_comb begin
    result           = '0;
    result.pwm_lines = lines_ext[4:0];
    if (item.command == CMD_GET_ONE && id_ok) begin
      result.read_valid = 1'b1;
      result.read_pos_a = read_one;
    end else if (item.command == CMD_GET_ALL) begin
      result.read_valid = 1'b1;
      result.read_pos_a = read_all[0];
      result.read_pos_b = read_all[1];
      result.read_pos_c = read_all[2];
      result.read_pos_d = read_all[3];
      result.read_pos_e = read_all[4];
    end
  end

  // reinit clears counter and lines
  a_reinit: assert property (@(posedge clk) disable iff (rst)
    !rst && go && item.command == CMD_REINIT |=> period_count == '0 && line_levels == '0)
    else $error("reinit did not clear counter and lines");

  // period restart loads the enable bits onto the lines
  a_restart: assert property (@(posedge clk) disable iff (rst)
    !rst && go && item.command == CMD_TICK && restart |=> line_levels == $past(enable_bits))
    else $error("period restart lines differ from enables");

  // lines only rise at a period restart
  a_no_rise: assert property (@(posedge clk) disable iff (rst)
    !rst && !(go && item.command == CMD_TICK && restart)
    |=> (line_levels & ~$past(line_levels)) == '0)
    else $error("line rose outside period restart");

  // counter moves only on tick or reinit
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !rst && !(go && (item.command == CMD_TICK || item.command == CMD_REINIT))
    |=> $stable(period_count))
    else $error("period counter moved without tick");

endmodule
`default_nettype wire

### sv/five_channel_servo_pwm_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// five_channel_servo_pwm_top
// Five-channel servo pulse generator with configuration registers.
// ----------------------------------------------------------------------------
// Each command word (a time tick or a servo command) yields one result word
// carrying the line levels after it and, for position reads, the angles.
// A word passes an input register, then the update logic, which writes the
// servo state and the output register together; a new word can be taken
// every cycle while the output register is not stalled. The output register
// holds a result until it is taken while the next word waits in the input
// register. Configuration writes must only happen while no word is in flight.
module five_channel_servo_pwm_top
  import fcsp_pkg::*;
#(
  parameter int SERVO_COUNT = 5
) (
  input  logic        clk,
  input  logic        rst,
  fcsp_cmd_if.sink    cmd,
  fcsp_res_if.source  res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  fcsp_cfg_t cfg;
  fcsp_cmd_t item;
  logic      item_valid;
  fcsp_res_t result;
  fcsp_res_t res_word;
  logic      res_valid;
  logic      go;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_ticks <= PERIOD_TICKS_RESET;
      cfg.pulse_limit  <= PULSE_LIMIT_RESET;
      cfg.pulse_base   <= PULSE_BASE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PERIOD_TICKS: cfg.period_ticks <= cfg_data;
        REG_PULSE_LIMIT:  cfg.pulse_limit  <= cfg_data;
        REG_PULSE_BASE:   cfg.pulse_base   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // handshake: process when the output register is free or being drained
  assign go        = item_valid && (!res_valid || res.ready);
  assign cmd.ready = !item_valid || go;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd.ready) begin
      item_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      item <= cmd.data;
    end
  end

  fcsp_core #(
    .SERVO_COUNT (SERVO_COUNT)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (go) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_word <= result;
    end
  end

  assign res.valid = res_valid;
  assign res.data  = res_word;

endmodule
`default_nettype wire
